// ===== hdl/saw_arq_pkg.sv =====
// ----------------------------------------------------------------------------
// saw_arq_pkg
// Shared types and constants of the stop-and-wait ARQ sender: event kinds,
// result status codes, controller states and fixed port field widths.
// ----------------------------------------------------------------------------
package saw_arq_pkg;

    // fixed field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int INLEN_W  = 11;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 9;
    localparam int OUTLEN_W = 11;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_SEND    = 2'd0,
        MODE_ACK     = 2'd1,
        MODE_NAK     = 2'd2,
        MODE_TIMEOUT = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FULL         = 2'd1,
        STATUS_ACK_EMPTY    = 2'd2,
        STATUS_RESEND_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

endpackage

// ===== hdl/saw_arq_ram.sv =====
// ----------------------------------------------------------------------------
// saw_arq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module saw_arq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/stop_and_wait_arq_sender.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender
// Stop-and-wait ARQ sender over a ring of packet slots held in a RAM.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one event word: tuser holds the event kind (send, ack,
//   nak, timeout), tdata the packet length used by a send.
//   m_axis returns exactly one result word per event: status and the
//   transmit flag in tuser, fill slot, transmit slot and length in tdata.
//   a send writes its length into the tail slot of the length RAM; an ack
//   or a resend reads the length of the head slot from the same RAM.
//   an event is accepted in the idle state; the lookup state then waits for
//   the registered read of the length RAM and loads the output register, so
//   no new event is taken before the block has returned to idle.
//   a new event is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the block holds the next result
//   in its lookup state and stops accepting until the output register frees.
//   reset empties the ring (head and tail at slot 0); the RAM is not cleared,
//   only slots written by a send are ever read.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender #(
    parameter int QUEUE_DEPTH = 512,
    parameter int LENGTH_BITS = 11
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_axis_tdata: packet_length[10:0], zero pad
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [saw_arq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // s_axis_tuser: mode[1:0]
    input  logic [saw_arq_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // m_axis_tdata: fill_slot[8:0], transmit_slot[17:9], transmit_length[28:18]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [saw_arq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // m_axis_tuser: status[1:0], transmit[2]
    output logic [saw_arq_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx == LAST_IDX) ? '0 : idx + 1'b1;
        return res;
    endfunction

    saw_arq_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;

    // pending result captured at accept
    saw_arq_pkg::status_t   status_reg, status_next;
    logic [IDX_W-1:0]       fill_reg, fill_next;
    logic                   tx_reg, tx_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   fwd_reg, fwd_next;
    logic [LENGTH_BITS-1:0] fwd_len_reg, fwd_len_next;

    // output register
    logic                                m_valid_reg, m_valid_next;
    logic [saw_arq_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [saw_arq_pkg::M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic                   load_out;
    saw_arq_pkg::mode_t     in_mode;
    logic [LENGTH_BITS-1:0] in_len;
    logic                   empty;
    logic [IDX_W-1:0]       head_inc;
    logic [IDX_W-1:0]       tail_inc;

    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [LENGTH_BITS-1:0] ram_rd_data;
    logic [LENGTH_BITS-1:0] tx_len;

    assign in_mode  = saw_arq_pkg::mode_t'(s_axis_tuser[saw_arq_pkg::MODE_W-1:0]);
    assign in_len   = LENGTH_BITS'(s_axis_tdata[saw_arq_pkg::INLEN_W-1:0]);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign empty    = (head_reg == tail_reg);
    assign head_inc = ring_next(head_reg);
    assign tail_inc = ring_next(tail_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            saw_arq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = saw_arq_pkg::ST_LOOKUP;
                end
            end
            saw_arq_pkg::ST_LOOKUP: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = saw_arq_pkg::ST_IDLE;
                end
            end
            default: state_next = saw_arq_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            saw_arq_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            saw_arq_pkg::ST_LOOKUP: load_out = !m_valid_reg || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                load_out      = 1'b0;
            end
        endcase
    end

    // event decode and pointer update
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        status_next  = status_reg;
        fill_next    = fill_reg;
        tx_next      = tx_reg;
        slot_next    = slot_reg;
        fwd_next     = fwd_reg;
        fwd_len_next = fwd_len_reg;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = (in_mode == saw_arq_pkg::MODE_ACK) ? head_inc : head_reg;
        if (accept) begin
            status_next  = saw_arq_pkg::STATUS_OK;
            fill_next    = '0;
            tx_next      = 1'b0;
            slot_next    = head_reg;
            fwd_next     = 1'b0;
            fwd_len_next = in_len;
            case (in_mode)
                saw_arq_pkg::MODE_SEND: begin
                    if (!empty && tail_inc == head_reg) begin
                        status_next = saw_arq_pkg::STATUS_FULL;
                    end else begin
                        ram_wr_en = 1'b1;
                        fill_next = tail_reg;
                        tail_next = tail_inc;
                        tx_next   = empty;
                        fwd_next  = 1'b1;
                    end
                end
                saw_arq_pkg::MODE_ACK: begin
                    if (empty) begin
                        status_next = saw_arq_pkg::STATUS_ACK_EMPTY;
                    end else begin
                        head_next = head_inc;
                        slot_next = head_inc;
                        tx_next   = (head_inc != tail_reg);
                        ram_rd_en = 1'b1;
                    end
                end
                default: begin
                    if (empty) begin
                        status_next = saw_arq_pkg::STATUS_RESEND_EMPTY;
                    end else begin
                        tx_next   = 1'b1;
                        ram_rd_en = 1'b1;
                    end
                end
            endcase
        end
    end

    saw_arq_ram #(
        .WIDTH (LENGTH_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (in_len),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // result word
    assign tx_len = fwd_reg ? fwd_len_reg : ram_rd_data;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_tdata_next = '0;
            m_tdata_next[saw_arq_pkg::SLOT_W-1:0] = saw_arq_pkg::SLOT_W'(fill_reg);
            if (tx_reg) begin
                m_tdata_next[2*saw_arq_pkg::SLOT_W-1:saw_arq_pkg::SLOT_W] =
                    saw_arq_pkg::SLOT_W'(slot_reg);
                m_tdata_next[2*saw_arq_pkg::SLOT_W+saw_arq_pkg::OUTLEN_W-1:
                             2*saw_arq_pkg::SLOT_W] = saw_arq_pkg::OUTLEN_W'(tx_len);
            end
            m_tuser_next = {tx_reg, status_reg};
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= saw_arq_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        fill_reg    <= fill_next;
        tx_reg      <= tx_next;
        slot_reg    <= slot_next;
        fwd_reg     <= fwd_next;
        fwd_len_reg <= fwd_len_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    // checks
    a_tx_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[saw_arq_pkg::STATUS_W] |->
            m_axis_tuser[saw_arq_pkg::STATUS_W-1:0] == saw_arq_pkg::STATUS_OK)
        else $error("transmit flagged on a failed event");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LAST_IDX && tail_reg <= LAST_IDX)
        else $error("ring pointer out of range");

    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == saw_arq_pkg::ST_LOOKUP && !s_axis_tready)
        else $error("accepted event did not enter lookup");

    a_wr_rd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("length ram written and read for one event");

    a_lookup_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_axis_tvalid && state_reg == saw_arq_pkg::ST_IDLE)
        else $error("result word not loaded");

endmodule

// ===== tb/stop_and_wait_arq_sender_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_tb
// Self-checking bench for the stop-and-wait ARQ sender. A table of directed
// event words runs first, then random events, a run that fills the ring until
// sends are dropped, a drain past empty and a random mix. Each result word is
// checked field by field against its table row or a ring model in the bench.
// Both stream sides stall at random in changing proportions, then not at all.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_tb;

    localparam int RING_SLOTS   = 512;
    localparam int TOTAL_WORDS  = 1725;
    localparam int PHASE_WORDS  = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        saw_arq_pkg::status_t                 status;
        logic [saw_arq_pkg::SLOT_W-1:0]       fill_slot;
        logic                                 transmit;
        logic [saw_arq_pkg::SLOT_W-1:0]       tx_slot;
        logic [saw_arq_pkg::OUTLEN_W-1:0]     tx_length;
    } arq_result_t;

    typedef struct {
        saw_arq_pkg::mode_t                   mode;
        logic [saw_arq_pkg::INLEN_W-1:0]      length;
        bit                                   typed;
        arq_result_t                          result;
    } stim_row_t;

    logic                                 aclk;
    logic                                 aresetn = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [saw_arq_pkg::S_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [saw_arq_pkg::S_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [saw_arq_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic [saw_arq_pkg::M_TUSER_W-1:0]    m_axis_tuser;

    // ring model
    logic [saw_arq_pkg::SLOT_W-1:0]       head_slot = '0;
    logic [saw_arq_pkg::SLOT_W-1:0]       tail_slot = '0;
    logic [saw_arq_pkg::OUTLEN_W-1:0]     slot_length [RING_SLOTS];
    arq_result_t                          pending_results[$];

    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     words_sent = 0;
    int                     src_idle_pct = 23;
    int                     dst_idle_pct = 45;
    bit                     word_typed = 1'b0;
    arq_result_t            word_result = '0;

    stop_and_wait_arq_sender dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [saw_arq_pkg::SLOT_W-1:0] next_slot(
        logic [saw_arq_pkg::SLOT_W-1:0] slot);
        return saw_arq_pkg::SLOT_W'(slot + 1'b1);
    endfunction

    function automatic int ring_count();
        return int'(saw_arq_pkg::SLOT_W'(tail_slot - head_slot));
    endfunction

    function automatic arq_result_t ring_update(saw_arq_pkg::mode_t mode,
                                                logic [saw_arq_pkg::INLEN_W-1:0] length);
        arq_result_t r;
        logic        was_empty;
        r = '0;
        r.status = saw_arq_pkg::STATUS_OK;
        was_empty = (head_slot == tail_slot);
        case (mode)
            saw_arq_pkg::MODE_SEND: begin
                if (next_slot(tail_slot) == head_slot) begin
                    r.status = saw_arq_pkg::STATUS_FULL;
                end else begin
                    r.fill_slot = tail_slot;
                    slot_length[tail_slot] = length;
                    tail_slot = next_slot(tail_slot);
                    r.transmit = was_empty;
                end
            end
            saw_arq_pkg::MODE_ACK: begin
                if (was_empty) begin
                    r.status = saw_arq_pkg::STATUS_ACK_EMPTY;
                end else begin
                    head_slot = next_slot(head_slot);
                    r.transmit = (head_slot != tail_slot);
                end
            end
            default: begin
                if (was_empty) begin
                    r.status = saw_arq_pkg::STATUS_RESEND_EMPTY;
                end else begin
                    r.transmit = 1'b1;
                end
            end
        endcase
        if (r.transmit) begin
            r.tx_slot = head_slot;
            r.tx_length = slot_length[head_slot];
        end
        return r;
    endfunction

    function automatic stim_row_t make_row(saw_arq_pkg::mode_t mode, int length,
                                           bit typed = 1'b0,
                                           saw_arq_pkg::status_t status =
                                               saw_arq_pkg::STATUS_OK,
                                           int fill = 0, bit transmit = 1'b0,
                                           int tx_slot = 0, int tx_length = 0);
        stim_row_t row;
        row.mode = mode;
        row.length = saw_arq_pkg::INLEN_W'(length);
        row.typed = typed;
        row.result.status = status;
        row.result.fill_slot = saw_arq_pkg::SLOT_W'(fill);
        row.result.transmit = transmit;
        row.result.tx_slot = saw_arq_pkg::SLOT_W'(tx_slot);
        row.result.tx_length = saw_arq_pkg::OUTLEN_W'(tx_length);
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < PRINT_LIMIT) begin
            $display("mismatch %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        error_count++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic drive_word(saw_arq_pkg::mode_t mode,
                              logic [saw_arq_pkg::INLEN_W-1:0] length,
                              bit typed = 1'b0, arq_result_t result = '0);
        if (words_sent < PHASE_WORDS) begin
            src_idle_pct = 23;
            dst_idle_pct = 45;
        end else if (words_sent < 2 * PHASE_WORDS) begin
            src_idle_pct = 45;
            dst_idle_pct = 23;
        end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {{(saw_arq_pkg::S_TDATA_W - saw_arq_pkg::INLEN_W){1'b0}}, length};
        word_typed = typed;
        word_result = result;
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drive_random(int send_pct);
        int                 pick;
        saw_arq_pkg::mode_t mode;
        pick = $urandom_range(99);
        if (pick < send_pct) begin
            mode = saw_arq_pkg::MODE_SEND;
        end else if (pick < send_pct + (100 - send_pct) * 2 / 3) begin
            mode = saw_arq_pkg::MODE_ACK;
        end else begin
            mode = $urandom_range(1) ? saw_arq_pkg::MODE_NAK : saw_arq_pkg::MODE_TIMEOUT;
        end
        drive_word(mode, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        arq_result_t predicted;
        arq_result_t want;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predicted = ring_update(saw_arq_pkg::mode_t'(s_axis_tuser),
                                    s_axis_tdata[saw_arq_pkg::INLEN_W-1:0]);
            pending_results.push_back(word_typed ? word_result : predicted);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", int'(m_axis_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser[1:0] !== want.status)
                    report_mismatch("status", int'(m_axis_tuser[1:0]), int'(want.status));
                if (m_axis_tdata[8:0] !== want.fill_slot)
                    report_mismatch("fill_slot", int'(m_axis_tdata[8:0]), int'(want.fill_slot));
                if (m_axis_tuser[2] !== want.transmit)
                    report_mismatch("transmit", int'(m_axis_tuser[2]), int'(want.transmit));
                if (m_axis_tdata[17:9] !== want.tx_slot)
                    report_mismatch("transmit_slot", int'(m_axis_tdata[17:9]),
                                    int'(want.tx_slot));
                if (m_axis_tdata[28:18] !== want.tx_length)
                    report_mismatch("transmit_length", int'(m_axis_tdata[28:18]),
                                    int'(want.tx_length));
            end
        end
    end

    initial begin
        stim_row_t directed[$];
        int        seg_pct;

        // events on the empty ring, then a short life of two packets
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0, 1,
                                    saw_arq_pkg::STATUS_ACK_EMPTY));
        directed.push_back(make_row(saw_arq_pkg::MODE_NAK, 0, 1,
                                    saw_arq_pkg::STATUS_RESEND_EMPTY));
        directed.push_back(make_row(saw_arq_pkg::MODE_TIMEOUT, 2047, 1,
                                    saw_arq_pkg::STATUS_RESEND_EMPTY));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 2047, 1,
                                    saw_arq_pkg::STATUS_OK, 0, 1, 0, 2047));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 0, 1,
                                    saw_arq_pkg::STATUS_OK, 1));
        directed.push_back(make_row(saw_arq_pkg::MODE_NAK, 0, 1,
                                    saw_arq_pkg::STATUS_OK, 0, 1, 0, 2047));
        directed.push_back(make_row(saw_arq_pkg::MODE_TIMEOUT, 0, 1,
                                    saw_arq_pkg::STATUS_OK, 0, 1, 0, 2047));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0, 1,
                                    saw_arq_pkg::STATUS_OK, 0, 1, 1, 0));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0, 1,
                                    saw_arq_pkg::STATUS_OK));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0, 1,
                                    saw_arq_pkg::STATUS_ACK_EMPTY));
        directed.push_back(make_row(saw_arq_pkg::MODE_TIMEOUT, 0, 1,
                                    saw_arq_pkg::STATUS_RESEND_EMPTY));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 1365, 1,
                                    saw_arq_pkg::STATUS_OK, 2, 1, 2, 1365));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 682));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 1024));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 1));
        directed.push_back(make_row(saw_arq_pkg::MODE_NAK, 2047));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 1365));
        directed.push_back(make_row(saw_arq_pkg::MODE_TIMEOUT, 682));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0));
        directed.push_back(make_row(saw_arq_pkg::MODE_NAK, 0));
        directed.push_back(make_row(saw_arq_pkg::MODE_SEND, 2047));
        directed.push_back(make_row(saw_arq_pkg::MODE_ACK, 0));

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            drive_word(directed[i].mode, directed[i].length, directed[i].typed,
                       directed[i].result);
        end

        repeat (300) drive_random(45);

        // fill the ring to its last free slot, then knock on it while full
        while (ring_count() != RING_SLOTS - 1) begin
            drive_word(saw_arq_pkg::MODE_SEND, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        end
        drive_word(saw_arq_pkg::MODE_SEND, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_NAK, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_SEND, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_TIMEOUT, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_SEND, saw_arq_pkg::INLEN_W'($urandom_range(2047)));

        // drain past empty
        while (ring_count() != 0) begin
            drive_random(0);
        end
        drive_word(saw_arq_pkg::MODE_ACK, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_NAK, saw_arq_pkg::INLEN_W'($urandom_range(2047)));
        drive_word(saw_arq_pkg::MODE_TIMEOUT, saw_arq_pkg::INLEN_W'($urandom_range(2047)));

        while (words_sent < TOTAL_WORDS) begin
            seg_pct = $urandom_range(25, 75);
            repeat (50) drive_random(seg_pct);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
